/* rtl/core/kt_pkg.sv */
package kt_pkg;

  // token kinds as seen on the output word
  typedef enum logic [4:0] {
    K_IDENT   = 5'd0,
    K_INT     = 5'd1,
    K_FUNC    = 5'd2,
    K_IF      = 5'd3,
    K_WHILE   = 5'd4,
    K_RETURN  = 5'd5,
    K_END     = 5'd6,
    K_LET     = 5'd7,
    K_LPAREN  = 5'd8,
    K_RPAREN  = 5'd9,
    K_COLON   = 5'd10,
    K_ASSIGN  = 5'd11,
    K_GT      = 5'd12,
    K_LT      = 5'd13,
    K_PLUS    = 5'd14,
    K_MINUS   = 5'd15,
    K_STAR    = 5'd16,
    K_SLASH   = 5'd17,
    K_UNKNOWN = 5'd18,
    K_EOF     = 5'd19
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_IDENT   = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_t;

  localparam int OFF_W  = 32;
  localparam int LEN_W  = 8;
  localparam int LINE_W = 20;
  localparam int COL_W  = 16;
  localparam int PREFIX_DEPTH = 6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LESS  = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GREAT = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    kind_t              kind;
    logic [OFF_W-1:0]   offset;
    logic [LEN_W-1:0]   length;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   column;
  } tok_t;

  // one queue entry: everything a single source byte produced
  // tok_a is the run closed by the byte, tok_b the byte's own token
  typedef struct packed {
    logic has_a;
    logic has_b;
    tok_t tok_a;
    tok_t tok_b;
  } qent_t;

endpackage

/* rtl/core/kt_byte_if.sv */
interface kt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink   (input valid, input source_byte, output ready);
endinterface

/* rtl/core/kt_token_if.sv */
interface kt_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [31:0] token_offset;
  logic [7:0]  token_length;
  logic [19:0] line_number;
  logic [15:0] column_number;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output line_number, output column_number,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_offset,
                  input token_length, input line_number, input column_number,
                  input last_of_run, output ready);
endinterface

/* rtl/core/kt_front.sv */
module kt_front #(
  parameter int MAX_TOKEN_LENGTH = 255
) (
  input  logic           clk,
  input  logic           rst,
  kt_byte_if.sink        src,
  input  logic           q_full,
  output logic           push,
  output kt_pkg::qent_t  push_data
);
  import kt_pkg::*;

  localparam int CW      = $clog2(MAX_TOKEN_LENGTH + 2);
  localparam int LEN_CAP = (MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255;

  mode_t             mode, mode_next;
  logic [OFF_W-1:0]  start_off, start_off_next;
  logic [CW-1:0]     count, count_next;
  logic [7:0]        prefix [PREFIX_DEPTH];
  logic [LINE_W-1:0] line, line_next;
  logic [COL_W-1:0]  col, col_next;
  logic [OFF_W-1:0]  off, off_next;

  logic [7:0]        c;
  logic              acc, is_let, is_num, is_blank;
  logic              cmt_stay, ext, closing, dispatch, b_valid;
  logic [LINE_W-1:0] line_c;
  logic [COL_W-1:0]  col_c;
  logic              pf_we;
  logic [2:0]        pf_idx;
  logic [CW-1:0]     run_base;
  logic [LEN_W-1:0]  run_len;
  kind_t             word_kind, b_kind;

  function automatic kind_t single_kind(input logic [7:0] ch);
    kind_t k;
    unique case (ch)
      CH_LPAR:  k = K_LPAREN;
      CH_RPAR:  k = K_RPAREN;
      CH_COLON: k = K_COLON;
      CH_EQ:    k = K_ASSIGN;
      CH_GREAT: k = K_GT;
      CH_LESS:  k = K_LT;
      CH_PLUS:  k = K_PLUS;
      CH_MINUS: k = K_MINUS;
      CH_STAR:  k = K_STAR;
      CH_SLASH: k = K_SLASH;
      default:  k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  assign c      = src.source_byte;
  assign src.ready = !q_full;
  assign acc    = src.valid && src.ready;

  assign is_let = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  assign is_num = (c >= "0" && c <= "9");
  assign is_blank = c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF
                 || c == CH_CR || c == CH_LF;

  assign cmt_stay = (mode == MODE_COMMENT) && c != CH_LF && c != CH_NUL;
  assign ext      = ((mode == MODE_IDENT) && (is_let || is_num))
                 || ((mode == MODE_NUMBER) && is_num);
  assign closing  = ((mode == MODE_IDENT) && !(is_let || is_num))
                 || ((mode == MODE_NUMBER) && !is_num);
  assign dispatch = !cmt_stay && !ext;
  assign b_valid  = dispatch && (c == CH_NUL || (!is_blank && c != CH_HASH
                                                 && !is_let && !is_num));

  // counters after this byte is consumed
  always_comb begin
    if (c == CH_LF || c == CH_CR) begin
      line_c = (line != '1) ? line + 1'b1 : line;
      col_c  = '0;
    end else begin
      line_c = line;
      col_c  = (col != '1) ? col + 1'b1 : col;
    end
  end

  // keyword match on the stored prefix; a long run never matches
  always_comb begin
    word_kind = K_IDENT;
    unique case (prefix[0])
      "f": if (count == CW'(4) && prefix[1] == "u" && prefix[2] == "n" && prefix[3] == "c")
             word_kind = K_FUNC;
      "i": if (count == CW'(2) && prefix[1] == "f")
             word_kind = K_IF;
      "w": if (count == CW'(5) && prefix[1] == "h" && prefix[2] == "i" && prefix[3] == "l"
               && prefix[4] == "e")
             word_kind = K_WHILE;
      "r": if (count == CW'(6) && prefix[1] == "e" && prefix[2] == "t" && prefix[3] == "u"
               && prefix[4] == "r" && prefix[5] == "n")
             word_kind = K_RETURN;
      "e": if (count == CW'(3) && prefix[1] == "n" && prefix[2] == "d")
             word_kind = K_END;
      "l": if (count == CW'(3) && prefix[1] == "e" && prefix[2] == "t")
             word_kind = K_LET;
      default: word_kind = K_IDENT;
    endcase
  end

  assign run_len = (count > CW'(LEN_CAP)) ? LEN_W'(LEN_CAP) : LEN_W'(count);
  assign b_kind  = (c == CH_NUL) ? K_EOF : single_kind(c);

  always_comb begin
    push_data.has_a        = closing;
    push_data.has_b        = b_valid;
    push_data.tok_a.kind   = (mode == MODE_NUMBER) ? K_INT : word_kind;
    push_data.tok_a.offset = start_off;
    push_data.tok_a.length = run_len;
    push_data.tok_a.line   = line;
    push_data.tok_a.column = col;
    push_data.tok_b.kind   = b_kind;
    push_data.tok_b.offset = off;
    push_data.tok_b.length = LEN_W'(1);
    push_data.tok_b.line   = line_c;
    push_data.tok_b.column = col_c;
  end

  assign push = acc && (closing || b_valid);

  // next state
  always_comb begin
    mode_next      = mode;
    start_off_next = start_off;
    count_next     = count;
    line_next      = line_c;
    col_next       = col_c;
    off_next       = off + 1'b1;
    pf_we          = 1'b0;
    pf_idx         = 3'd0;
    run_base       = count;
    if (ext) begin
      pf_we  = (count < CW'(PREFIX_DEPTH));
      pf_idx = count[2:0];
    end
    if (dispatch) begin
      mode_next = MODE_IDLE;
      priority if (c == CH_NUL) begin
        start_off_next = '0;
        count_next     = '0;
        line_next      = LINE_W'(1);
        col_next       = '0;
        off_next       = '0;
      end else if (c == CH_HASH) begin
        mode_next = MODE_COMMENT;
      end else if (is_let || is_num) begin
        mode_next      = is_let ? MODE_IDENT : MODE_NUMBER;
        start_off_next = off;
        run_base       = '0;
        pf_we          = 1'b1;
        pf_idx         = 3'd0;
      end else begin
        // blank or single-byte token: back to idle
        mode_next = MODE_IDLE;
      end
    end
    if (ext || (dispatch && c != CH_NUL && (is_let || is_num))) begin
      count_next = (run_base < CW'(MAX_TOKEN_LENGTH + 1)) ? run_base + 1'b1 : run_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      start_off <= '0;
      count     <= '0;
      line      <= LINE_W'(1);
      col       <= '0;
      off       <= '0;
    end else if (acc) begin
      mode      <= mode_next;
      start_off <= start_off_next;
      count     <= count_next;
      line      <= line_next;
      col       <= col_next;
      off       <= off_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && pf_we) prefix[pf_idx] <= c;
  end

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && c == CH_NUL) |=> (line == LINE_W'(1) && col == '0 && off == '0
                              && mode == MODE_IDLE))
    else $error("counters not restarted after end of source");

  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDENT || mode == MODE_NUMBER) |-> count != '0)
    else $error("open run with zero length");

endmodule

/* rtl/core/kt_queue.sv */
module kt_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kt_pkg::qent_t  push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output kt_pkg::qent_t  head_data
);
  import kt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  qent_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] fill;

  assign full       = (fill == NW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_entry_has_token: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_data.has_a || push_data.has_b))
    else $error("empty entry pushed");

endmodule

/* rtl/core/kt_back.sv */
module kt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  kt_pkg::qent_t  head_data,
  output logic           pop,
  kt_token_if.source     tok
);
  import kt_pkg::*;

  logic  a_done;
  logic  out_valid;
  tok_t  out_tok;
  logic  out_last;

  logic  load, take_a;
  tok_t  sel_tok;
  logic  sel_last;

  assign load     = head_valid && (!out_valid || tok.ready);
  assign take_a   = head_data.has_a && !a_done;
  assign sel_tok  = take_a ? head_data.tok_a : head_data.tok_b;
  assign sel_last = take_a ? !head_data.has_b : 1'b1;
  // an entry with two tokens stays at the head until its second one goes out
  assign pop      = load && !(take_a && head_data.has_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_done    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        a_done    <= take_a && head_data.has_b;
        out_valid <= 1'b1;
      end else if (tok.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= sel_tok;
      out_last <= sel_last;
    end
  end

  assign tok.valid         = out_valid;
  assign tok.token_kind    = out_tok.kind;
  assign tok.token_offset  = out_tok.offset;
  assign tok.token_length  = out_tok.length;
  assign tok.line_number   = out_tok.line;
  assign tok.column_number = out_tok.column;
  assign tok.last_of_run   = out_last;

  a_split_pending: assert property (@(posedge clk) disable iff (rst)
    a_done |-> (head_valid && head_data.has_a && head_data.has_b))
    else $error("split entry lost from head");

  a_second_is_last: assert property (@(posedge clk) disable iff (rst)
    (load && !take_a) |=> (out_valid && out_last))
    else $error("second token not marked last");

endmodule

/* rtl/core/keyword_tokenizer.sv */
// Channel | Dir | Modport            | Word
// src     | in  | kt_byte_if.sink    | one source byte, 0 = end of source
// tok     | out | kt_token_if.source | one token: kind, offset, length, line, column, last
//
// One source byte is accepted per cycle while the token queue has room.
// A byte that only closes a run, or only makes its own token, yields one output
// token; a byte that does both yields two, and the output register moves one token
// per cycle when not stalled. Each passes a queue slot, then the output register.
// Reset (rst, synchronous) clears mode and counters; no clearing pass.
// Output stalls back up through the queue and then drop src.ready.
module keyword_tokenizer #(
  parameter int MAX_TOKEN_LENGTH = 255,
  parameter int QUEUE_DEPTH      = 4
) (
  input  logic       clk,
  input  logic       rst,
  kt_byte_if.sink    src,
  kt_token_if.source tok
);
  import kt_pkg::*;

  // front -> queue
  logic  push;
  qent_t push_data;
  logic  q_full;
  // queue -> back
  logic  pop;
  logic  head_valid;
  qent_t head_data;

  // front: classifies each byte, tracks line/column/offset, builds the
  // closing token of an open run and the byte's own token in one entry
  kt_front #(
    .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .src       (src),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // short queue so a stalled output does not stop the scanner at once
  kt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // back: splits each entry into one or two output words, marks the last
  kt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .tok        (tok)
  );

endmodule
